/* hw/rtl/avm_pkg.sv */
// Shared types and constants for the assertion vector monitor.
`default_nettype none

package avm_pkg;

   localparam int unsigned GROUP_COUNT = 8;
   localparam int unsigned ORBIT_REGS  = 4;
   localparam int unsigned ORBIT_W     = 18;
   localparam int unsigned STATE_OUT_W = 18;

   // layer group masks over the low state bits
   localparam logic [ORBIT_W-1:0] GROUP_MASK [GROUP_COUNT] = '{
      18'h00007, 18'h00038, 18'h001C0, 18'h00600,
      18'h01800, 18'h02000, 18'h04000, 18'h38000
   };

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_ORBIT_COUNT = 3'd0;
   localparam logic [2:0] REG_ORBIT_ZERO  = 3'd1;
   localparam logic [2:0] REG_ORBIT_ONE   = 3'd2;
   localparam logic [2:0] REG_ORBIT_TWO   = 3'd3;
   localparam logic [2:0] REG_ORBIT_THREE = 3'd4;

   // phase codes
   localparam logic [2:0] PHASE_NONE      = 3'd0;
   localparam logic [2:0] PHASE_LOW       = 3'd1;
   localparam logic [2:0] PHASE_MID       = 3'd2;
   localparam logic [2:0] PHASE_HIGH      = 3'd3;
   localparam logic [2:0] PHASE_IMPROVING = 3'd4;

   localparam int unsigned PHASE_LOW_MAX = 3;
   localparam int unsigned PHASE_MID_MAX = 8;

   typedef struct packed {
      logic [2:0]                          orbit_count;
      logic [ORBIT_REGS-1:0][ORBIT_W-1:0]  orbit;
   } avm_cfg_type;

   // per-beat evaluation results, field widths as delivered
   typedef struct packed {
      logic [17:0]        masked_state;
      logic [4:0]         sigma;
      logic [2:0]         worst_grp;
      logic [1:0]         fracture;
      logic [4:0]         orbit_distance;
      logic [1:0]         orbit_index;
      logic [2:0]         phase;
      logic signed [5:0]  lagrangian_scaled;
      logic [17:0]        recovered_state;
   } avm_eval_type;

endpackage

`default_nettype wire

/* hw/rtl/avm_csr.sv */
// Configuration register file: orbit count and four reference orbits.
`default_nettype none

module avm_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic      [31:0]        csr_prdata,
   output logic                    csr_pready,
   output avm_pkg::avm_cfg_type    cfg_o
);
   import avm_pkg::*;

   logic [2:0]         count_ff;
   logic [ORBIT_W-1:0] orbit_ff [ORBIT_REGS];
   logic [2:0]         index;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd1;
         for (int i = 0; i < ORBIT_REGS; i++) orbit_ff[i] <= '0;
      end else if (wr_en) begin
         case (index)
            REG_ORBIT_COUNT: count_ff    <= csr_pwdata[2:0];
            REG_ORBIT_ZERO:  orbit_ff[0] <= csr_pwdata[ORBIT_W-1:0];
            REG_ORBIT_ONE:   orbit_ff[1] <= csr_pwdata[ORBIT_W-1:0];
            REG_ORBIT_TWO:   orbit_ff[2] <= csr_pwdata[ORBIT_W-1:0];
            REG_ORBIT_THREE: orbit_ff[3] <= csr_pwdata[ORBIT_W-1:0];
            default: ;  // unmapped, dropped
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_ORBIT_COUNT: csr_prdata = {29'd0, count_ff};
         REG_ORBIT_ZERO:  csr_prdata = {14'd0, orbit_ff[0]};
         REG_ORBIT_ONE:   csr_prdata = {14'd0, orbit_ff[1]};
         REG_ORBIT_TWO:   csr_prdata = {14'd0, orbit_ff[2]};
         REG_ORBIT_THREE: csr_prdata = {14'd0, orbit_ff[3]};
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg_o.orbit_count = count_ff;
      for (int i = 0; i < ORBIT_REGS; i++) cfg_o.orbit[i] = orbit_ff[i];
   end

endmodule

`default_nettype wire

/* hw/rtl/avm_eval.sv */
// Single-pass evaluation: popcounts, layer stats, orbit search, phase, lagrangian.
`default_nettype none

module avm_eval #(
   parameter int unsigned ASSERTION_WIDTH = 18,
   parameter int unsigned ORBIT_SLOTS     = 4,
   parameter int unsigned SIG_W           = $clog2(ASSERTION_WIDTH + 1),
   parameter int unsigned LAG_W           = SIG_W + 2
) (
   input  wire logic [31:0]              raw_bits,
   input  wire avm_pkg::avm_cfg_type     cfg_i,
   input  wire logic [SIG_W-1:0]         sigma_hold,
   input  wire logic [2:0]               worst_hold,
   output avm_pkg::avm_eval_type         eval_o,
   output logic [SIG_W-1:0]              sigma_full,
   output logic signed [LAG_W-1:0]       lag_full,
   output logic [2:0]                    worst_next
);
   import avm_pkg::*;

   localparam int unsigned W      = ASSERTION_WIDTH;
   localparam int unsigned DIST_W = $clog2(W + 2);
   localparam int unsigned N_CMP  = (ORBIT_SLOTS < ORBIT_REGS) ? ORBIT_SLOTS : ORBIT_REGS;

   logic [W-1:0]       state;
   logic [1:0]         grp_cnt [GROUP_COUNT];
   logic [1:0]         max_c, min_c;
   logic [DIST_W-1:0]  orb_dist [N_CMP];
   logic [DIST_W-1:0]  best_dist;
   logic [1:0]         best_idx;
   logic [2:0]         limit;
   logic [W-1:0]       diff, low_bit, recovered;
   logic [2:0]         phase;

   assign state = raw_bits[W-1:0];

   // total set bits
   always_comb begin
      sigma_full = '0;
      for (int b = 0; b < W; b++) sigma_full = sigma_full + SIG_W'(state[b]);
   end

   // layer groups: first strict max wins, empty vector keeps the held layer
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_cnt[g] = '0;
         for (int b = 0; b < ORBIT_W; b++)
            grp_cnt[g] = grp_cnt[g] + 2'(state[b] & GROUP_MASK[g][b]);
      end
      max_c      = '0;
      min_c      = grp_cnt[0];
      worst_next = worst_hold;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         if (grp_cnt[g] > max_c) begin
            max_c      = grp_cnt[g];
            worst_next = 3'(g);
         end
         if (grp_cnt[g] < min_c) min_c = grp_cnt[g];
      end
   end

   // orbit search, count clamped to 1..N_CMP
   always_comb begin
      if (cfg_i.orbit_count == 3'd0)                 limit = 3'd1;
      else if (cfg_i.orbit_count > 3'(N_CMP))        limit = 3'(N_CMP);
      else                                           limit = cfg_i.orbit_count;
      for (int i = 0; i < N_CMP; i++) begin
         orb_dist[i] = '0;
         for (int b = 0; b < W; b++) begin
            if (b < ORBIT_W)
               orb_dist[i] = orb_dist[i] + DIST_W'(state[b] ^ cfg_i.orbit[i][b]);
            else
               orb_dist[i] = orb_dist[i] + DIST_W'(state[b]);
         end
      end
      best_dist = DIST_W'(W + 1);
      best_idx  = '0;
      for (int i = 0; i < N_CMP; i++) begin
         if ((3'(i) < limit) && (orb_dist[i] < best_dist)) begin
            best_dist = orb_dist[i];
            best_idx  = 2'(i);
         end
      end
   end

   // flip lowest bit differing from the nearest orbit
   assign diff      = state ^ W'(cfg_i.orbit[best_idx]);
   assign low_bit   = diff & (~diff + W'(1));
   assign recovered = state ^ low_bit;

   always_comb begin
      if (sigma_full == '0)                       phase = PHASE_NONE;
      else if (sigma_full <= SIG_W'(PHASE_LOW_MAX)) phase = PHASE_LOW;
      else if (sigma_full <= SIG_W'(PHASE_MID_MAX)) phase = PHASE_MID;
      else                                        phase = PHASE_HIGH;
      if (sigma_full < sigma_hold)                phase = PHASE_IMPROVING;
   end

   assign lag_full = $signed(LAG_W'(W)) - $signed({1'b0, sigma_full, 1'b0});

   always_comb begin
      eval_o.masked_state      = state[STATE_OUT_W-1:0];
      eval_o.sigma             = sigma_full[4:0];
      eval_o.worst_grp         = worst_next;
      eval_o.fracture          = max_c - min_c;
      eval_o.orbit_distance    = best_dist[4:0];
      eval_o.orbit_index       = best_idx;
      eval_o.phase             = phase;
      eval_o.lagrangian_scaled = lag_full[5:0];
      eval_o.recovered_state   = recovered[STATE_OUT_W-1:0];
   end

endmodule

`default_nettype wire

/* hw/rtl/assertion_vector_monitor_unit.sv */
// Top level of the assertion vector monitor: beat pipeline, running state, CSRs.
`default_nettype none

// Channel   Dir  Width  Contents
// req_*     in   32     assertion_bits
// rsp_*     out  128    masked_state .. step_count, packed low to high
// csr_*     in   5/32   APB registers: orbit_count, orbit_zero..orbit_three
//
// Two register stages: an input register, one pass of evaluation logic, then
// the result register. One beat per cycle unless a held result stalls the
// pipe; a beat is captured in the input register, and rsp_tvalid rises when
// it moves on into the result register. A held result stalls the input
// register only once it is full, so the input side keeps taking beats while
// a result waits. The running state (previous sigma, worst layer, action sum,
// step count) updates as a beat moves into the result register. Reset clears
// all control and state; registers come back at orbit_count 1, orbits 0.

module assertion_vector_monitor_unit #(
   parameter int unsigned ASSERTION_WIDTH = 18,
   parameter int unsigned ORBIT_SLOTS     = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // [31:0] assertion_bits
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [17:0] masked_state, [22:18] sigma, [25:23] worst_grp, [27:26] fracture,
   // [32:28] orbit_distance, [34:33] orbit_index, [37:35] phase,
   // [43:38] lagrangian_scaled, [75:44] action_sum, [93:76] recovered_state,
   // [125:94] step_count, [127:126] zero
   output logic [127:0]       rsp_tdata,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [4:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import avm_pkg::*;

   localparam int unsigned SIG_W = $clog2(ASSERTION_WIDTH + 1);
   localparam int unsigned LAG_W = SIG_W + 2;

   avm_cfg_type              cfg;
   avm_eval_type             eval;
   logic [SIG_W-1:0]         sigma_full;
   logic signed [LAG_W-1:0]  lag_full;
   logic [2:0]               worst_next;

   logic                     in_valid_ff, in_valid_in;
   logic [31:0]              in_data_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [127:0]             out_data_ff, out_data_in;

   logic [SIG_W-1:0]         sigma_hold_ff;
   logic [2:0]               worst_ff;
   logic signed [31:0]       acc_ff, acc_in;
   logic [31:0]              step_ff, step_in;

   logic                     advance;
   logic                     take_in;
   logic signed [32:0]       sum_wide;

   avm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_o       (cfg)
   );

   avm_eval #(
      .ASSERTION_WIDTH (ASSERTION_WIDTH),
      .ORBIT_SLOTS     (ORBIT_SLOTS),
      .SIG_W           (SIG_W),
      .LAG_W           (LAG_W)
   ) u_eval (
      .raw_bits   (in_data_ff),
      .cfg_i      (cfg),
      .sigma_hold (sigma_hold_ff),
      .worst_hold (worst_ff),
      .eval_o     (eval),
      .sigma_full (sigma_full),
      .lag_full   (lag_full),
      .worst_next (worst_next)
   );

   // handshake: result slot frees when empty or being taken
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign take_in    = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign in_valid_in  = take_in | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   // saturating accumulate into 32-bit signed
   assign sum_wide = {acc_ff[31], acc_ff} + {{(33 - LAG_W){lag_full[LAG_W-1]}}, lag_full};
   always_comb begin
      if (sum_wide[32] != sum_wide[31])
         acc_in = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else
         acc_in = sum_wide[31:0];
   end

   assign step_in = step_ff + 32'd1;

   assign out_data_in = {2'b00, step_in, eval.recovered_state, acc_in,
                         eval.lagrangian_scaled, eval.phase, eval.orbit_index,
                         eval.orbit_distance, eval.fracture, eval.worst_grp,
                         eval.sigma, eval.masked_state};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         sigma_hold_ff <= '0;
         worst_ff      <= '0;
         acc_ff        <= '0;
         step_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            sigma_hold_ff <= sigma_full;
            worst_ff      <= worst_next;
            acc_ff        <= acc_in;
            step_ff       <= step_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_in) in_data_ff  <= req_tdata;
      if (advance) out_data_ff <= out_data_in;
   end

`ifndef ASSERT_OFF
   // each beat moving to the result slot bumps the step count by exactly one
   a_step_inc: assert property (@(posedge clock) disable iff (reset)
      advance |=> (step_ff == $past(step_ff) + 32'd1))
      else $error("step counter did not advance with the beat");

   // a full pipe with a stalled output must not take a new beat
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages full");

   // the held result carries the current step count and action sum
   a_step_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (rsp_tdata[125:94] == step_ff))
      else $error("result step_count out of sync with counter");

   a_sum_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (rsp_tdata[75:44] == acc_ff))
      else $error("result action_sum out of sync with accumulator");
`endif

endmodule

`default_nettype wire
